### design/mmpd_pkg.sv
// Shared types and constants for the min/max/peak waveform decimator.
// No dependencies; every other file of the block imports this package.
package mmpd_pkg;

  localparam int SAMPLE_BITS    = 24;
  localparam int COUNT_BITS     = 16;
  localparam int REM_BITS       = COUNT_BITS + 1;
  localparam int CFG_INDEX_BITS = 8;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic        [SAMPLE_BITS-1:0] mag_t;
  typedef logic        [COUNT_BITS-1:0]  count_t;
  typedef logic        [REM_BITS-1:0]    rem_t;
  typedef logic        [CFG_INDEX_BITS-1:0] cfg_index_t;

  localparam cfg_index_t REG_FRAME_LENGTH = cfg_index_t'(0);
  localparam cfg_index_t REG_BIN_COUNT    = cfg_index_t'(1);

  localparam count_t FRAME_LENGTH_RESET = count_t'(4096);
  localparam count_t BIN_COUNT_RESET    = count_t'(1024);

  // Statistics of the open bin, including the word just taken.
  typedef struct packed {
    sample_t peak;
    sample_t min;
    sample_t max;
  } stats_t;

  // Control from the bin sequencer to the statistics tracker.
  typedef struct packed {
    logic step;      // a valid sample enters the open bin
    logic bin_done;  // this sample closes the bin
    logic clear;     // drop all frame state
  } stats_ctrl_t;

endpackage

### design/mmpd_if.sv
// Handshake interfaces of the decimator: sample input, result output, config writes.
// Depends on mmpd_pkg for payload types.
interface mmpd_sample_if;
  import mmpd_pkg::*;
  logic    valid;
  logic    ready;
  sample_t sample;
  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface mmpd_result_if;
  import mmpd_pkg::*;
  logic    valid;
  logic    ready;
  sample_t peak_sample;
  sample_t bin_min;
  sample_t bin_max;
  count_t  bin_number;
  logic    frame_end;
  logic    config_error;
  modport source (output valid, output peak_sample, output bin_min, output bin_max,
                  output bin_number, output frame_end, output config_error,
                  input ready);
  modport sink   (input valid, input peak_sample, input bin_min, input bin_max,
                  input bin_number, input frame_end, input config_error,
                  output ready);
endinterface

interface mmpd_cfg_if;
  import mmpd_pkg::*;
  logic       valid;
  logic       ready;
  cfg_index_t index;
  count_t     data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### design/mmpd_bin_stats.sv
// Running min, max and first-largest-magnitude tracker for the open bin.
// Depends on mmpd_pkg; driven by the bin sequencer in the top level.
module mmpd_bin_stats (
  input  logic                 clk,
  input  logic                 rst,
  input  mmpd_pkg::stats_ctrl_t ctrl,
  input  mmpd_pkg::sample_t    sample,
  output mmpd_pkg::stats_t     stats_next
);
  import mmpd_pkg::*;

  logic    active;
  sample_t run_min;
  sample_t run_max;
  sample_t run_peak;
  mag_t    run_mag;

  logic    first;
  mag_t    mag;
  mag_t    base_mag;
  mag_t    mag_next;

  always_comb begin
    first    = !active;
    mag      = sample[SAMPLE_BITS-1] ? mag_t'(-sample) : mag_t'(sample);
    base_mag = first ? '0 : run_mag;
    stats_next.peak = first ? '0 : run_peak;
    mag_next        = base_mag;
    if (mag > base_mag) begin
      stats_next.peak = sample;
      mag_next        = mag;
    end
    if (first) begin
      stats_next.min = sample;
      stats_next.max = sample;
    end else begin
      stats_next.min = (sample < run_min) ? sample : run_min;
      stats_next.max = (sample > run_max) ? sample : run_max;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      active <= 1'b0;
    end else if (ctrl.step) begin
      active   <= !ctrl.bin_done;
      run_min  <= stats_next.min;
      run_max  <= stats_next.max;
      run_peak <= stats_next.peak;
      run_mag  <= mag_next;
    end
  end

endmodule

### design/min_max_peak_decimator.sv
// Top level of the min/max/peak waveform decimator: config registers, bin
// boundary sequencer and result register. Depends on mmpd_pkg, mmpd_if, mmpd_bin_stats.
//
//   port     dir   word                                                    width
//   cfg      in    index, data (frame_length = 0, bin_count = 1)           8 + 16
//   samples  in    sample                                                  24
//   results  out   peak_sample, bin_min, bin_max, bin_number,              24x3 + 16
//                  frame_end, config_error                                 + 1 + 1
//
// One sample per cycle unless the result stalls; a closed bin reaches the result
// register in the cycle after its last sample. The remainder subtract and compare
// sets the path. rst restores frame_length 4096, bin_count 1024 and an empty frame.
// Any config write drops the frame in progress. A stalled result holds
// samples off only while the result register is full and not taken.
module min_max_peak_decimator (
  input logic          clk,
  input logic          rst,
  mmpd_cfg_if.sink     cfg,
  mmpd_sample_if.sink  samples,
  mmpd_result_if.source results
);
  import mmpd_pkg::*;

  count_t frame_length;
  count_t bin_count;
  count_t sample_counter;
  count_t bin_counter;
  rem_t   boundary_remainder;

  logic        accept;
  logic        bad_cfg;
  rem_t        n_ext;
  rem_t        m_ext;
  rem_t        r_cur;
  rem_t        r_sub;
  rem_t        cnt_next;
  logic        close;
  logic        last;
  stats_ctrl_t ctrl;
  stats_t      stats_next;

  assign cfg.ready     = 1'b1;
  assign samples.ready = !results.valid || results.ready;
  assign accept        = samples.valid && samples.ready;

  always_comb begin
    n_ext    = {1'b0, frame_length};
    m_ext    = {1'b0, bin_count};
    bad_cfg  = (bin_count == '0) || (bin_count >= frame_length);
    r_cur    = (sample_counter == '0) ? n_ext : boundary_remainder;
    r_sub    = (r_cur >= m_ext) ? r_cur - m_ext : '0;
    cnt_next = {1'b0, sample_counter} + rem_t'(1);
    close    = r_sub < m_ext;
    last     = cnt_next >= n_ext;
    ctrl.step     = accept && !bad_cfg;
    ctrl.bin_done = close;
    ctrl.clear    = (cfg.valid && cfg.ready) || (accept && (bad_cfg || (close && last)));
  end

  mmpd_bin_stats u_stats (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .sample     (samples.sample),
    .stats_next (stats_next)
  );

  // config registers and bin sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_length       <= FRAME_LENGTH_RESET;
      bin_count          <= BIN_COUNT_RESET;
      sample_counter     <= '0;
      bin_counter        <= '0;
      boundary_remainder <= '0;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_FRAME_LENGTH: frame_length <= cfg.data;
        REG_BIN_COUNT:    bin_count    <= cfg.data;
        default:          ;
      endcase
      sample_counter     <= '0;
      bin_counter        <= '0;
      boundary_remainder <= '0;
    end else if (accept) begin
      if (bad_cfg || (close && last)) begin
        sample_counter     <= '0;
        bin_counter        <= '0;
        boundary_remainder <= '0;
      end else if (close) begin
        sample_counter     <= cnt_next[COUNT_BITS-1:0];
        bin_counter        <= bin_counter + count_t'(1);
        boundary_remainder <= r_sub + n_ext;
      end else begin
        sample_counter     <= cnt_next[COUNT_BITS-1:0];
        boundary_remainder <= r_sub;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (accept && (bad_cfg || close)) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (bad_cfg || close)) begin
      if (bad_cfg) begin
        results.peak_sample  <= '0;
        results.bin_min      <= '0;
        results.bin_max      <= '0;
        results.bin_number   <= '0;
        results.frame_end    <= 1'b0;
        results.config_error <= 1'b1;
      end else begin
        results.peak_sample  <= stats_next.peak;
        results.bin_min      <= stats_next.min;
        results.bin_max      <= stats_next.max;
        results.bin_number   <= bin_counter;
        results.frame_end    <= last;
        results.config_error <= 1'b0;
      end
    end
  end

endmodule

### sim/mmpd_bin_checker.sv
// Scoreboard for min_max_peak_decimator: watches the config, sample and result
// channels, predicts every closed bin and compares it field by field.
// Depends on mmpd_pkg and the interfaces in mmpd_if.
module mmpd_bin_checker (
  input  logic   clk,
  input  logic   rst,
  mmpd_cfg_if    cfg,
  mmpd_sample_if samples,
  mmpd_result_if results,
  output int     fail_count,
  output int     bins_pending
);
  import mmpd_pkg::*;

  typedef logic signed [63:0] wide_t;

  typedef struct {
    sample_t peak;
    sample_t lo;
    sample_t hi;
    count_t  bin;
    logic    last;
    logic    bad_cfg;
  } bin_summary_t;

  bin_summary_t expected_bins [$];
  bin_summary_t want;

  count_t  frame_len;
  count_t  bins_per_frame;
  count_t  frame_pos;
  count_t  bin_idx;
  rem_t    boundary;
  sample_t lo;
  sample_t hi;
  sample_t peak;
  mag_t    peak_mag;
  logic    bin_open;

  function automatic void drop_frame();
    frame_pos = '0;
    bin_idx   = '0;
    boundary  = '0;
    lo        = '0;
    hi        = '0;
    peak      = '0;
    peak_mag  = '0;
    bin_open  = 1'b0;
  endfunction

  function automatic void predict_bin(sample_t s);
    rem_t         r;
    mag_t         mag;
    bin_summary_t res;
    res = '{default: '0};
    if (bins_per_frame == '0 || bins_per_frame >= frame_len) begin
      drop_frame();
      res.bad_cfg = 1'b1;
      expected_bins.push_back(res);
      return;
    end
    // remainder is (bin+1)*N - samples*M; a fresh frame starts it at N
    r   = (frame_pos == '0) ? rem_t'(frame_len) : boundary;
    mag = s[SAMPLE_BITS-1] ? mag_t'(-s) : mag_t'(s);
    if (!bin_open) begin
      lo       = s;
      hi       = s;
      peak     = '0;
      peak_mag = '0;
      bin_open = 1'b1;
    end else begin
      if (s < lo) lo = s;
      if (s > hi) hi = s;
    end
    // strict compare keeps the first sample on a magnitude tie
    if (mag > peak_mag) begin
      peak_mag = mag;
      peak     = s;
    end
    r = (r >= rem_t'(bins_per_frame)) ? r - rem_t'(bins_per_frame) : '0;
    frame_pos = frame_pos + count_t'(1);
    if (r < rem_t'(bins_per_frame)) begin
      res.peak = peak;
      res.lo   = lo;
      res.hi   = hi;
      res.bin  = bin_idx;
      res.last = (frame_pos >= frame_len);
      expected_bins.push_back(res);
      if (res.last) begin
        drop_frame();
      end else begin
        bin_idx  = bin_idx + count_t'(1);
        boundary = r + rem_t'(frame_len);
        bin_open = 1'b0;
      end
    end else begin
      boundary = r;
    end
  endfunction

  function automatic void check_field(string name, wide_t expected_val, wide_t seen);
    if (seen !== expected_val) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, expected_val, seen);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      frame_len      = FRAME_LENGTH_RESET;
      bins_per_frame = BIN_COUNT_RESET;
      drop_frame();
      expected_bins.delete();
    end else begin
      // retire the oldest bin before this edge's sample adds a new one
      if (results.valid && results.ready) begin
        if (expected_bins.size() == 0) begin
          $display("%0t: unexpected word: expected none, got bin %0d peak %0d err %0d",
                   $time, results.bin_number, results.peak_sample, results.config_error);
          fail_count++;
        end else begin
          want = expected_bins.pop_front();
          check_field("peak_sample", want.peak, results.peak_sample);
          check_field("bin_min", want.lo, results.bin_min);
          check_field("bin_max", want.hi, results.bin_max);
          check_field("bin_number", want.bin, results.bin_number);
          check_field("frame_end", want.last, results.frame_end);
          check_field("config_error", want.bad_cfg, results.config_error);
        end
      end
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == REG_FRAME_LENGTH) frame_len = cfg.data;
        else if (cfg.index == REG_BIN_COUNT) bins_per_frame = cfg.data;
        drop_frame();
      end
      if (samples.valid && samples.ready) predict_bin(samples.sample);
    end
    bins_pending = expected_bins.size();
  end

endmodule

### sim/min_max_peak_decimator_test.sv
// Testbench top for min_max_peak_decimator: clock, reset, sample and config
// stimulus, result back-pressure and the verdict. Depends on mmpd_pkg, mmpd_if
// and mmpd_bin_checker.
module min_max_peak_decimator_test;
  import mmpd_pkg::*;

  localparam int RESET_CYCLES  = 4;
  localparam int SETTLE_CYCLES = 4;
  localparam int LONG_HOLD     = 80;
  localparam int IDLE_LIMIT    = 2000;
  localparam int RANDOM_ITEMS  = 1100;
  localparam int SAMPLE_LOW    = -(2 ** (SAMPLE_BITS - 1));
  localparam int SAMPLE_HIGH   = 2 ** (SAMPLE_BITS - 1) - 1;
  localparam cfg_index_t REG_UNUSED = '1;

  typedef enum {DRAIN_FULL, DRAIN_HALF, DRAIN_SLOW, DRAIN_EVERY_THIRD} drain_mode_t;

  // four bins of four: all zero, extremes, magnitude ties, negative peak
  int directed_bins [16] = '{0, 0, 0, 0,
                             SAMPLE_HIGH, SAMPLE_LOW, -1, 1,
                             5, -5, 5, -5,
                             -7, 7, 3, -2};
  int corner_samples [5] = '{SAMPLE_LOW, SAMPLE_HIGH, 0, -1, 1};

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  int      fail_count;
  int      bins_pending;
  int      hold_requests;
  int      burst_left;
  int      samples_sent;
  sample_t last_pick;

  always #1 clk = ~clk;

  mmpd_cfg_if    cfg_bus ();
  mmpd_sample_if sample_bus ();
  mmpd_result_if result_bus ();

  min_max_peak_decimator uut (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_bus),
    .samples (sample_bus),
    .results (result_bus)
  );

  mmpd_bin_checker u_bin_check (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg_bus),
    .samples      (sample_bus),
    .results      (result_bus),
    .fail_count   (fail_count),
    .bins_pending (bins_pending)
  );

  function automatic sample_t pick_sample();
    sample_t s;
    int      roll;
    roll = $urandom_range(0, 9);
    if (roll < 4) s = sample_t'($urandom);
    else if (roll < 6) s = sample_t'($urandom_range(0, 32)) - sample_t'(16);
    else if (roll == 6) s = sample_t'(corner_samples[3'($urandom_range(0, 4))]);
    else if (roll == 7) s = '0;
    else s = ($urandom_range(0, 1) == 1) ? -last_pick : last_pick;  // magnitude tie
    last_pick = s;
    return s;
  endfunction

  // offer one word in bursts with random gaps; return once it is taken
  task automatic send_sample(sample_t s);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk);
        sample_bus.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    @(negedge clk);
    sample_bus.valid  <= 1'b1;
    sample_bus.sample <= s;
    do @(posedge clk); while (!sample_bus.ready);
    burst_left--;
    samples_sent++;
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    sample_bus.valid <= 1'b0;
    burst_left = 0;
    while (bins_pending != 0) @(negedge clk);
  endtask

  // drain, then let a bin still in flight settle before touching registers
  task automatic go_quiet();
    wait_for_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(cfg_index_t idx, count_t value);
    @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    do @(posedge clk); while (!cfg_bus.ready);
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic set_frame(count_t n, count_t m);
    go_quiet();
    if ($urandom_range(0, 1) == 1) begin
      write_reg(REG_FRAME_LENGTH, n);
      write_reg(REG_BIN_COUNT, m);
    end else begin
      write_reg(REG_BIN_COUNT, m);
      write_reg(REG_FRAME_LENGTH, n);
    end
  endtask

  task automatic run_phase(count_t n, count_t m, int items, bit long_hold);
    int k;
    set_frame(n, m);
    if (long_hold) hold_requests++;
    for (k = 0; k < items; k++) begin
      if (k == items / 2 && (long_hold || $urandom_range(0, 3) == 0)) wait_for_results();
      send_sample(pick_sample());
    end
  endtask

  // result side: random back-pressure patterns, plus one long hold on request
  initial begin : result_drain
    drain_mode_t mode;
    int          span;
    int          holds_done;
    result_bus.ready = 1'b0;
    mode = DRAIN_FULL;
    span = 0;
    holds_done = 0;
    forever begin
      @(negedge clk);
      if (hold_requests != holds_done) begin
        result_bus.ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
        holds_done++;
      end else begin
        if (span == 0) begin
          mode = drain_mode_t'($urandom_range(0, 3));
          span = $urandom_range(20, 200);
        end
        span--;
        case (mode)
          DRAIN_FULL:  result_bus.ready <= 1'b1;
          DRAIN_HALF:  result_bus.ready <= ($urandom_range(0, 1) == 1);
          DRAIN_SLOW:  result_bus.ready <= ($urandom_range(0, 3) == 0);
          default:     result_bus.ready <= (span % 3 == 0);
        endcase
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((sample_bus.valid && sample_bus.ready) || (result_bus.valid && result_bus.ready) ||
          (cfg_bus.valid && cfg_bus.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    count_t n;
    count_t m;
    int     k;
    int     roll;
    sample_bus.valid  = 1'b0;
    sample_bus.sample = '0;
    cfg_bus.valid     = 1'b0;
    cfg_bus.index     = '0;
    cfg_bus.data      = '0;
    hold_requests     = 0;
    burst_left        = 0;
    last_pick         = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: default frame gives bins of four samples
    for (k = 0; k < 16; k++) send_sample(sample_t'(directed_bins[4'(k)]));
    // leave a partial bin, then drop it with a write to an unmapped index
    send_sample(sample_t'(9));
    send_sample(sample_t'(-3));
    go_quiet();
    write_reg(REG_UNUSED, '1);
    for (k = 4; k < 8; k++) send_sample(sample_t'(directed_bins[4'(k)]));
    // bad settings: bin count equal to frame length, zero bins, tiny frame
    set_frame(count_t'(8), count_t'(8));
    send_sample(sample_t'(SAMPLE_LOW));
    set_frame(count_t'(8), count_t'(0));
    send_sample(sample_t'(SAMPLE_HIGH));
    set_frame(count_t'(1), count_t'(0));
    send_sample(sample_t'(-1));

    samples_sent = 0;
    run_phase(count_t'(2), count_t'(1), 40, 1'b0);
    run_phase('1, count_t'(16'hFFFE), 150, 1'b0);
    run_phase(count_t'(12), count_t'(6), 70, 1'b1);
    while (samples_sent < RANDOM_ITEMS) begin
      roll = $urandom_range(0, 11);
      if (roll == 0) begin
        n = count_t'($urandom_range(0, 65535));
        if ($urandom_range(0, 2) == 0) m = '0;
        else m = count_t'($urandom_range(n, 65535));
        run_phase(n, m, $urandom_range(3, 10), 1'b0);
      end else if (roll == 1) begin
        n = count_t'($urandom_range(1024, 65535));
        m = n - count_t'($urandom_range(1, 40));
        run_phase(n, m, $urandom_range(40, 120), 1'b0);
      end else begin
        n = count_t'($urandom_range(2, 48));
        m = count_t'($urandom_range(1, n - 1));
        run_phase(n, m, $urandom_range(20, 120), 1'b0);
      end
    end

    go_quiet();
    if (fail_count == 0 && bins_pending == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
